// File: sv/point_density_matrix_render_top_defines.svh
// Assertion macros used by pdmr_ctrl.
// Define NO_ASSERTIONS to compile them out.
`ifndef POINT_DENSITY_MATRIX_RENDER_TOP_DEFINES_SVH
`define POINT_DENSITY_MATRIX_RENDER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PDMR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdmr assertion failed");

// Next-cycle implication.
`define PDMR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdmr assertion failed");

`else

`define PDMR_ASSERT_IMP(label, clk, rst, ante, cons)
`define PDMR_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/pdmr_pkg.sv
`timescale 1ns / 1ps

package pdmr_pkg;

   localparam int MATRIX_COLS_DEF = 8;
   localparam int MATRIX_ROWS_DEF = 8;

   localparam int COORD_W  = 16;
   localparam int CFG_W    = 4;
   localparam int POS_W    = 3;
   localparam int COUNT_W  = 9;
   localparam int LEVEL_W  = 8;
   localparam int CSR_IDX_W = 1;

   localparam int FULL_LEVEL = 255;
   localparam int COUNT_MAX  = 511;

   // restoring divide of FULL_LEVEL, one quotient bit per step
   localparam int DIV_STEPS = LEVEL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_IN_USE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_IN_USE = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_IN_USE_RST  = 4'd8;
   localparam logic [CFG_W-1:0] HEIGHT_IN_USE_RST = 4'd8;

   typedef struct packed {
      logic point_accept;
      logic point_update;
      logic frame_accept;
      logic div_step;
      logic walk_read;
      logic out_load;
      logic walk_next;
      logic frame_clear;
   } pdmr_cmd_type;

   typedef struct packed {
      logic div_last;
      logic walk_last;
   } pdmr_status_type;

endpackage

// File: sv/pdmr_ram.sv
`timescale 1ns / 1ps

module pdmr_ram #(
   parameter int WIDTH  = 9,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pdmr_datapath.sv
`timescale 1ns / 1ps

module pdmr_datapath #(
   parameter int MATRIX_COLS = pdmr_pkg::MATRIX_COLS_DEF,
   parameter int MATRIX_ROWS = pdmr_pkg::MATRIX_ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [pdmr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pdmr_pkg::CFG_W-1:0]           csr_wr_data,
   input  logic signed [pdmr_pkg::COORD_W-1:0]  req_x_pos,
   input  logic signed [pdmr_pkg::COORD_W-1:0]  req_y_pos,
   input  pdmr_pkg::pdmr_cmd_type               cmd,
   output pdmr_pkg::pdmr_status_type            status,
   output logic [pdmr_pkg::POS_W-1:0]           rsp_pixel_col,
   output logic [pdmr_pkg::POS_W-1:0]           rsp_pixel_row,
   output logic [pdmr_pkg::LEVEL_W-1:0]         rsp_pixel_level,
   output logic                                 rsp_frame_last
);

   localparam int STORE_DEPTH = MATRIX_COLS * MATRIX_ROWS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int IDX_W       = 2 * pdmr_pkg::POS_W + 1;
   localparam int MAG_W       = pdmr_pkg::COORD_W - 1;
   localparam int COUNT_W     = pdmr_pkg::COUNT_W;
   localparam int LEVEL_W     = pdmr_pkg::LEVEL_W;
   localparam int POS_W       = pdmr_pkg::POS_W;
   localparam int PROD_W      = COUNT_W + LEVEL_W;

   // configuration
   logic [pdmr_pkg::CFG_W-1:0] width_cfg_ff, width_cfg_in;
   logic [pdmr_pkg::CFG_W-1:0] height_cfg_ff, height_cfg_in;

   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pdmr_pkg::CSR_WIDTH_IN_USE:  width_cfg_in  = csr_wr_data;
            pdmr_pkg::CSR_HEIGHT_IN_USE: height_cfg_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= pdmr_pkg::WIDTH_IN_USE_RST;
         height_cfg_ff <= pdmr_pkg::HEIGHT_IN_USE_RST;
      end else begin
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
      end
   end

   // point range check and store index
   logic [MAG_W-1:0]  x_mag, y_mag;
   logic              x_ok, y_ok, pt_keep;
   logic [IDX_W-1:0]  idx_wide;
   logic [ADDR_W-1:0] pt_idx;

   assign x_mag = req_x_pos[MAG_W-1:0];
   assign y_mag = req_y_pos[MAG_W-1:0];
   assign x_ok  = !req_x_pos[pdmr_pkg::COORD_W-1]
                  && (x_mag < MAG_W'(width_cfg_ff)) && (x_mag < MAG_W'(MATRIX_COLS));
   assign y_ok  = !req_y_pos[pdmr_pkg::COORD_W-1]
                  && (y_mag < MAG_W'(height_cfg_ff)) && (y_mag < MAG_W'(MATRIX_ROWS));
   assign pt_keep  = x_ok && y_ok;
   assign idx_wide = IDX_W'(x_mag[POS_W-1:0]) * IDX_W'(MATRIX_ROWS)
                     + IDX_W'(y_mag[POS_W-1:0]);
   assign pt_idx   = pt_keep ? idx_wide[ADDR_W-1:0] : '0;

   logic [ADDR_W-1:0] idx_ff;
   logic              keep_ff;

   always_ff @(posedge clock) begin
      if (cmd.point_accept) begin
         idx_ff  <= pt_idx;
         keep_ff <= pt_keep;
      end
   end

   // walk counters, column-major so the store address just counts up
   logic [ADDR_W-1:0] walk_addr_ff, walk_addr_in;
   logic [POS_W-1:0]  walk_col_ff, walk_col_in;
   logic [POS_W-1:0]  walk_row_ff, walk_row_in;
   logic              walk_row_end;

   assign walk_row_end = (walk_row_ff == POS_W'(MATRIX_ROWS - 1));

   always_comb begin
      walk_addr_in = walk_addr_ff;
      walk_col_in  = walk_col_ff;
      walk_row_in  = walk_row_ff;
      if (cmd.frame_accept) begin
         walk_addr_in = '0;
         walk_col_in  = '0;
         walk_row_in  = '0;
      end else if (cmd.walk_next) begin
         walk_addr_in = walk_addr_ff + ADDR_W'(1);
         if (walk_row_end) begin
            walk_row_in = '0;
            walk_col_in = walk_col_ff + POS_W'(1);
         end else begin
            walk_row_in = walk_row_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_addr_ff <= '0;
         walk_col_ff  <= '0;
         walk_row_ff  <= '0;
      end else begin
         walk_addr_ff <= walk_addr_in;
         walk_col_ff  <= walk_col_in;
         walk_row_ff  <= walk_row_in;
      end
   end

   assign status.walk_last = walk_row_end && (walk_col_ff == POS_W'(MATRIX_COLS - 1));

   // hit count store; entries without a valid bit read as zero
   logic [STORE_DEPTH-1:0] valid_ff, valid_in;
   logic                   rd_valid_ff;
   logic                   rd_en, wr_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [COUNT_W-1:0]     rd_data, count_old, count_new;

   assign rd_en   = cmd.point_accept || cmd.walk_read;
   assign rd_addr = cmd.point_accept ? pt_idx : walk_addr_ff;
   assign wr_en   = cmd.point_update && keep_ff;

   assign count_old = rd_valid_ff ? rd_data : '0;
   assign count_new = (count_old == COUNT_W'(pdmr_pkg::COUNT_MAX))
                      ? count_old : count_old + COUNT_W'(1);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.frame_clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   pdmr_ram #(
      .WIDTH  (COUNT_W),
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (count_new),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // kept point total, saturating
   logic [COUNT_W-1:0] total_ff, total_in;

   always_comb begin
      total_in = total_ff;
      if (cmd.frame_clear) begin
         total_in = '0;
      end else if (wr_en && (total_ff != COUNT_W'(pdmr_pkg::COUNT_MAX))) begin
         total_in = total_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // interval = FULL_LEVEL / total, restoring divide, one bit per step
   logic [COUNT_W-1:0]            rem_ff, rem_in, rem_sh;
   logic [LEVEL_W-1:0]            quo_ff, quo_in;
   logic [pdmr_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                          div_ge;

   // dividend is all ones, so each step shifts in a one
   assign rem_sh = {rem_ff[COUNT_W-2:0], 1'b1};
   assign div_ge = (rem_sh >= total_ff);

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.frame_accept) begin
         rem_in     = '0;
         quo_in     = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in     = div_ge ? (rem_sh - total_ff) : rem_sh;
         quo_in     = {quo_ff[LEVEL_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff + pdmr_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else begin
         div_cnt_ff <= div_cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.div_last = (div_cnt_ff == pdmr_pkg::DIV_CNT_W'(pdmr_pkg::DIV_STEPS - 1));

   // pixel level and output register
   logic               interval_zero;
   logic [LEVEL_W-1:0] interval;
   logic [PROD_W-1:0]  product;
   logic [LEVEL_W-1:0] level;

   assign interval_zero = (total_ff == '0)
                          || (total_ff > COUNT_W'(pdmr_pkg::FULL_LEVEL));
   assign interval = interval_zero ? '0 : quo_ff;
   assign product  = PROD_W'(count_old) * PROD_W'(interval);
   assign level    = (product > PROD_W'(pdmr_pkg::FULL_LEVEL))
                     ? LEVEL_W'(pdmr_pkg::FULL_LEVEL) : product[LEVEL_W-1:0];

   logic [POS_W-1:0]   out_col_ff, out_row_ff;
   logic [LEVEL_W-1:0] out_level_ff;
   logic               out_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_col_ff   <= walk_col_ff;
         out_row_ff   <= walk_row_ff;
         out_level_ff <= level;
         out_last_ff  <= status.walk_last;
      end
   end

   assign rsp_pixel_col   = out_col_ff;
   assign rsp_pixel_row   = out_row_ff;
   assign rsp_pixel_level = out_level_ff;
   assign rsp_frame_last  = out_last_ff;

endmodule

// File: sv/pdmr_ctrl.sv
`timescale 1ns / 1ps
`include "point_density_matrix_render_top_defines.svh"

module pdmr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_func,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pdmr_pkg::pdmr_cmd_type     cmd,
   input  pdmr_pkg::pdmr_status_type  status
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_UPDATE = 6'b000010,
      S_DIV    = 6'b000100,
      S_FETCH  = 6'b001000,
      S_LOAD   = 6'b010000,
      S_HOLD   = 6'b100000
   } pdmr_state_type;

   pdmr_state_type state_ff, state_in;
   logic           req_xfer, rsp_xfer;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_HOLD);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func) begin
                  cmd.frame_accept = 1'b1;
                  state_in         = S_DIV;
               end else begin
                  cmd.point_accept = 1'b1;
                  state_in         = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            cmd.point_update = 1'b1;
            state_in         = S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.walk_read = 1'b1;
            state_in      = S_LOAD;
         end
         S_LOAD: begin
            cmd.out_load = 1'b1;
            state_in     = S_HOLD;
         end
         S_HOLD: begin
            if (rsp_ready) begin
               if (status.walk_last) begin
                  cmd.frame_clear = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  cmd.walk_next = 1'b1;
                  state_in      = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PDMR_ASSERT_NXT(a_point_updates, clock, reset, req_xfer && !req_func, state_ff == S_UPDATE)
   `PDMR_ASSERT_NXT(a_frame_divides, clock, reset, req_xfer && req_func, state_ff == S_DIV)
   `PDMR_ASSERT_NXT(a_last_pixel_idle, clock, reset, rsp_xfer && status.walk_last, req_ready)
   `PDMR_ASSERT_IMP(a_clear_on_last, clock, reset, cmd.frame_clear, rsp_xfer && status.walk_last)

endmodule

// File: sv/point_density_matrix_render_top.sv
// Point item: accepted when idle, then a store read followed by a counter write-back.
// Frame end: a bit-serial divide for the interval, then per pixel a store read, a level
// multiply into the output register and a hold for rsp_ready, plus any rsp_ready stall.
// A new item is accepted the cycle after the last pixel of a frame transfers.
// Reset (synchronous, active high) clears hit counts, total and state; both
// in-use registers return to eight.
`timescale 1ns / 1ps

module point_density_matrix_render_top #(
   parameter int MATRIX_COLS = pdmr_pkg::MATRIX_COLS_DEF,
   parameter int MATRIX_ROWS = pdmr_pkg::MATRIX_ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [pdmr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pdmr_pkg::CFG_W-1:0]           csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic signed [pdmr_pkg::COORD_W-1:0]  req_x_pos,
   input  logic signed [pdmr_pkg::COORD_W-1:0]  req_y_pos,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pdmr_pkg::POS_W-1:0]           rsp_pixel_col,
   output logic [pdmr_pkg::POS_W-1:0]           rsp_pixel_row,
   output logic [pdmr_pkg::LEVEL_W-1:0]         rsp_pixel_level,
   output logic                                 rsp_frame_last
);

   pdmr_pkg::pdmr_cmd_type    cmd;
   pdmr_pkg::pdmr_status_type status;

   pdmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pdmr_datapath #(
      .MATRIX_COLS (MATRIX_COLS),
      .MATRIX_ROWS (MATRIX_ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .cmd             (cmd),
      .status          (status),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_pixel_level (rsp_pixel_level),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule
